// ===== rtl/lmfl_pkg.sv =====
`timescale 1ns / 1ps

package lmfl_pkg;

    localparam int MAX_PAT_DEFAULT  = 32;
    localparam int MAX_TEXT_DEFAULT = 65536;

    localparam int SYMBOL_W = 8;
    localparam int FRAME_W  = 3;
    localparam int START_W  = 18;
    localparam int END_W    = 19;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam int NT_PER_CODON = 3;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_PLUS_1  = 3'd1;
    localparam logic [FRAME_W-1:0] FRAME_PLUS_2  = 3'd2;
    localparam logic [FRAME_W-1:0] FRAME_REV_0   = 3'd3;
    localparam logic [FRAME_W-1:0] FRAME_MINUS_1 = 3'd4;
    localparam logic [FRAME_W-1:0] FRAME_MINUS_2 = 3'd5;

endpackage

// ===== rtl/last_match_frame_locator.sv =====
`timescale 1ns / 1ps

// Finds the last, possibly overlapping, occurrence of a loaded byte pattern in a streamed
// reading frame and reports its corrected codon coordinates. Load the pattern with tuser = 0
// (tlast on its final byte), then stream the frame with tuser = 1 (tlast on its final byte);
// one result transaction follows each frame end, raising m_axis_tvalid once the result has
// passed the stage-1 and stage-2 registers and reached the output register.
// The block takes one byte per clock cycle: each text byte does a single read of a
// 256-entry position-mask memory, addressed by the byte, and one shift-and update of the
// MAX_PAT-bit match vector. Input is held off only while a frame result waits for the
// output to be taken. No clearing pass is needed after reset.
module last_match_frame_locator #(
    parameter int MAX_PAT  = lmfl_pkg::MAX_PAT_DEFAULT,
    parameter int MAX_TEXT = lmfl_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // symbol [7:0], frame_index [10:8], zero [15:11]
    input  logic [lmfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    // command [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found [0], start_coord [18:1], end_coord [37:19], overflow [38], zero [39]
    output logic [lmfl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PAT_IDX_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int LEN_W     = $clog2(MAX_PAT + 1);
    localparam int COUNT_W   = $clog2(MAX_TEXT + 1);
    localparam int POS_W     = $clog2(MAX_TEXT);
    localparam int CW        = (COUNT_W + 3 > lmfl_pkg::END_W) ? COUNT_W + 3 : lmfl_pkg::END_W;
    localparam int SYMS      = 2 ** lmfl_pkg::SYMBOL_W;
    localparam int RES_W     = 1 + lmfl_pkg::START_W + lmfl_pkg::END_W + 1;

    // position masks per symbol
    logic [MAX_PAT-1:0] pmask_mem [SYMS];
    logic [SYMS-1:0]    pmask_valid_reg, pmask_valid_next;
    logic [MAX_PAT-1:0] rd_mask_reg;
    logic               rd_valid_reg;

    logic [LEN_W-1:0] pattern_length_reg, pattern_length_next;
    logic             pattern_closed_reg, pattern_closed_next;

    logic                     s_acc;
    logic                     in_cmd;
    logic [lmfl_pkg::SYMBOL_W-1:0] in_sym;
    logic [lmfl_pkg::FRAME_W-1:0]  in_frame;
    logic                     pat_wr;
    logic                     pat_store;
    logic [LEN_W-1:0]         wr_len;
    logic [PAT_IDX_W-1:0]     wr_pos;
    logic                     wr_entry_valid;
    logic [MAX_PAT-1:0]       wr_onehot;

    // stage 1
    logic                         v1_reg;
    logic                         cmd1_reg;
    logic                         last1_reg;
    logic [lmfl_pkg::FRAME_W-1:0] frame1_reg;

    logic [MAX_PAT-1:0] match_vec_reg, match_vec_next;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic [POS_W-1:0]   last_pos_reg, last_pos_next;
    logic               seen_reg, seen_next;
    logic               sat_reg, sat_next;

    logic [MAX_PAT-1:0] b_mask;
    logic [MAX_PAT-1:0] upd_vec;
    logic [COUNT_W-1:0] upd_count;
    logic [POS_W-1:0]   upd_pos;
    logic               upd_seen;
    logic               upd_sat;
    logic               res_load;

    // stage 2
    logic                         v2_reg;
    logic [lmfl_pkg::FRAME_W-1:0] frame2_reg;
    logic                         seen2_reg;
    logic [POS_W-1:0]             pos2_reg;
    logic [LEN_W-1:0]             len2_reg;
    logic [COUNT_W-1:0]           count2_reg;
    logic                         sat2_reg;

    logic [CW-1:0] s_base, e_base, e_sum, fsize3, offset, s_coord, e_coord;

    logic                           out_valid_reg;
    logic [lmfl_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [RES_W-1:0]               res_word;

    logic stall;
    logic adv;

    assign stall = out_valid_reg && !m_axis_tready &&
                   ((v1_reg && cmd1_reg == lmfl_pkg::CMD_TEXT && last1_reg) || v2_reg);
    assign adv   = !stall;

    assign s_axis_tready = adv;
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign in_cmd   = s_axis_tuser;
    assign in_sym   = s_axis_tdata[lmfl_pkg::SYMBOL_W-1:0];
    assign in_frame = s_axis_tdata[lmfl_pkg::SYMBOL_W +: lmfl_pkg::FRAME_W];

    // pattern load, stage 0
    assign pat_wr         = s_acc && in_cmd == lmfl_pkg::CMD_PATTERN;
    assign wr_len         = pattern_closed_reg ? '0 : pattern_length_reg;
    assign pat_store      = pat_wr && wr_len < LEN_W'(MAX_PAT);
    assign wr_pos         = PAT_IDX_W'(wr_len);
    assign wr_entry_valid = !pattern_closed_reg && pmask_valid_reg[in_sym];
    assign wr_onehot      = MAX_PAT'(1) << wr_pos;

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        pattern_closed_next = pattern_closed_reg;
        pmask_valid_next    = pmask_valid_reg;
        if (pat_wr)
        begin
            pattern_length_next = wr_len;
            if (pattern_closed_reg)
            begin
                pmask_valid_next = '0;
            end
            if (pat_store)
            begin
                pattern_length_next      = wr_len + LEN_W'(1);
                pmask_valid_next[in_sym] = 1'b1;
            end
            pattern_closed_next = s_axis_tlast;
        end
        else if (s_acc)
        begin
            pattern_closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_store)
        begin
            if (wr_entry_valid)
            begin
                pmask_mem[in_sym][wr_pos] <= 1'b1;
            end
            else
            begin
                pmask_mem[in_sym] <= wr_onehot;
            end
        end
        if (s_acc)
        begin
            rd_mask_reg  <= pmask_mem[in_sym];
            rd_valid_reg <= pmask_valid_reg[in_sym];
        end
    end

    // shift-and update, stage 1
    assign b_mask = rd_valid_reg ? rd_mask_reg : '0;

    always_comb
    begin
        upd_vec   = match_vec_reg;
        upd_count = char_count_reg;
        upd_pos   = last_pos_reg;
        upd_seen  = seen_reg;
        upd_sat   = sat_reg;
        res_load  = 1'b0;

        match_vec_next  = match_vec_reg;
        char_count_next = char_count_reg;
        last_pos_next   = last_pos_reg;
        seen_next       = seen_reg;
        sat_next        = sat_reg;

        if (v1_reg && adv)
        begin
            if (cmd1_reg == lmfl_pkg::CMD_PATTERN)
            begin
                match_vec_next  = '0;
                char_count_next = '0;
                last_pos_next   = '0;
                seen_next       = 1'b0;
                sat_next        = 1'b0;
            end
            else
            begin
                if (char_count_reg >= COUNT_W'(MAX_TEXT))
                begin
                    upd_sat = 1'b1;
                end
                else
                begin
                    upd_vec = ((match_vec_reg << 1) | MAX_PAT'(1)) & b_mask;
                    if (pattern_length_reg != '0 &&
                        upd_vec[PAT_IDX_W'(pattern_length_reg - LEN_W'(1))])
                    begin
                        upd_pos  = POS_W'(char_count_reg + COUNT_W'(1)
                                          - COUNT_W'(pattern_length_reg));
                        upd_seen = 1'b1;
                    end
                    upd_count = char_count_reg + COUNT_W'(1);
                end
                if (last1_reg)
                begin
                    res_load        = 1'b1;
                    match_vec_next  = '0;
                    char_count_next = '0;
                    last_pos_next   = '0;
                    seen_next       = 1'b0;
                    sat_next        = 1'b0;
                end
                else
                begin
                    match_vec_next  = upd_vec;
                    char_count_next = upd_count;
                    last_pos_next   = upd_pos;
                    seen_next       = upd_seen;
                    sat_next        = upd_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cmd1_reg   <= in_cmd;
            last1_reg  <= s_axis_tlast;
            frame1_reg <= in_frame;
        end
        if (adv && res_load)
        begin
            frame2_reg <= frame1_reg;
            seen2_reg  <= upd_seen;
            pos2_reg   <= upd_pos;
            len2_reg   <= pattern_length_reg;
            count2_reg <= upd_count;
            sat2_reg   <= upd_sat;
        end
        if (adv && v2_reg)
        begin
            out_data_reg <= lmfl_pkg::OUT_DATA_W'(res_word);
        end
    end

    // coordinate correction, stage 2
    always_comb
    begin
        s_base  = (CW'(pos2_reg) << 1) + CW'(pos2_reg);
        e_sum   = CW'(pos2_reg) + CW'(len2_reg);
        e_base  = (e_sum << 1) + e_sum;
        fsize3  = ((CW'(count2_reg) - CW'(1)) << 1) + (CW'(count2_reg) - CW'(1));
        offset  = CW'(frame2_reg) - CW'(lmfl_pkg::FRAME_REV_0);
        s_coord = s_base;
        e_coord = e_base;
        if (frame2_reg inside {lmfl_pkg::FRAME_PLUS_1, lmfl_pkg::FRAME_PLUS_2})
        begin
            s_coord = s_base + CW'(frame2_reg);
            e_coord = e_base + CW'(frame2_reg);
        end
        else if (frame2_reg inside {lmfl_pkg::FRAME_MINUS_1, lmfl_pkg::FRAME_MINUS_2})
        begin
            s_coord = fsize3 - s_base + offset;
            e_coord = fsize3 - e_base + offset;
        end
        if (!seen2_reg)
        begin
            s_coord = '0;
            e_coord = '0;
        end
        res_word = {sat2_reg, e_coord[lmfl_pkg::END_W-1:0],
                    s_coord[lmfl_pkg::START_W-1:0], seen2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmask_valid_reg    <= '0;
            pattern_length_reg <= '0;
            pattern_closed_reg <= 1'b1;
            v1_reg             <= 1'b0;
            match_vec_reg      <= '0;
            char_count_reg     <= '0;
            last_pos_reg       <= '0;
            seen_reg           <= 1'b0;
            sat_reg            <= 1'b0;
            v2_reg             <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            pmask_valid_reg    <= pmask_valid_next;
            pattern_length_reg <= pattern_length_next;
            pattern_closed_reg <= pattern_closed_next;
            match_vec_reg      <= match_vec_next;
            char_count_reg     <= char_count_next;
            last_pos_reg       <= last_pos_next;
            seen_reg           <= seen_next;
            sat_reg            <= sat_next;
            if (adv)
            begin
                v1_reg <= s_acc;
                v2_reg <= res_load;
            end
            if (adv && v2_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v2_reg |=> out_valid_reg)
        else $error("frame result did not reach the output register");

    a_hold_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> out_valid_reg && !m_axis_tready)
        else $error("input held off without a waiting result");

    a_pattern_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && adv && cmd1_reg == lmfl_pkg::CMD_PATTERN
        |=> char_count_reg == '0 && !seen_reg && match_vec_reg == '0)
        else $error("pattern byte left frame state behind");

    a_seen_implies_count: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> char_count_reg != '0)
        else $error("match recorded with no text counted");

endmodule

// ===== tb/sv/last_match_frame_locator_checker.sv =====
`timescale 1ns / 1ps

module last_match_frame_locator_checker #(
    parameter int MAX_PAT  = lmfl_pkg::MAX_PAT_DEFAULT,
    parameter int MAX_TEXT = lmfl_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [lmfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lmfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              failures,
    output int                              pending
);

    // packed to match the output bus, found in the lowest bit
    typedef struct packed {
        logic                         overflow;
        logic [lmfl_pkg::END_W-1:0]   end_coord;
        logic [lmfl_pkg::START_W-1:0] start_coord;
        logic                         found;
    } location_t;

    logic [lmfl_pkg::SYMBOL_W-1:0] pattern_store [MAX_PAT];
    int                            pattern_len;
    logic                          pattern_closed;
    logic [MAX_PAT-1:0]            cell_hits;
    int                            text_count;
    int                            match_pos;
    logic                          match_seen;
    logic                          count_saturated;

    location_t expected_locations[$];
    int        error_count;
    int        mismatch_count;

    task automatic clear_frame_state();
        cell_hits       = '0;
        text_count      = 0;
        match_pos       = 0;
        match_seen      = 1'b0;
        count_saturated = 1'b0;
    endtask

    task automatic scan_symbol(input logic [lmfl_pkg::SYMBOL_W-1:0] sym);
        int   k;
        logic prev;
        if (text_count >= MAX_TEXT)
        begin
            count_saturated = 1'b1;
            return;
        end
        // top cell first so each cell sees the previous vector
        for (k = pattern_len - 1; k >= 0; k--)
        begin
            prev = (k == 0) ? 1'b1 : cell_hits[k-1];
            cell_hits[k] = prev && (pattern_store[k] == sym);
        end
        if (pattern_len > 0 && cell_hits[pattern_len-1])
        begin
            match_pos  = text_count + 1 - pattern_len;
            match_seen = 1'b1;
        end
        text_count++;
    endtask

    task automatic close_frame(input logic [lmfl_pkg::FRAME_W-1:0] frm);
        location_t loc;
        int        s;
        int        e;
        int        fsize;
        int        off;
        s = 0;
        e = 0;
        if (match_seen)
        begin
            fsize = text_count - 1;
            s = match_pos * lmfl_pkg::NT_PER_CODON;
            e = (match_pos + pattern_len) * lmfl_pkg::NT_PER_CODON;
            if (frm == lmfl_pkg::FRAME_PLUS_1 || frm == lmfl_pkg::FRAME_PLUS_2)
            begin
                s += int'(frm);
                e += int'(frm);
            end
            else if (frm == lmfl_pkg::FRAME_MINUS_1 || frm == lmfl_pkg::FRAME_MINUS_2)
            begin
                off = int'(frm) - int'(lmfl_pkg::FRAME_REV_0);
                s = fsize * lmfl_pkg::NT_PER_CODON - (s - off);
                e = fsize * lmfl_pkg::NT_PER_CODON - (e - off);
            end
        end
        loc.found       = match_seen;
        loc.start_coord = s[lmfl_pkg::START_W-1:0];
        loc.end_coord   = e[lmfl_pkg::END_W-1:0];
        loc.overflow    = count_saturated;
        expected_locations = {expected_locations, loc};
        clear_frame_state();
    endtask

    task automatic predict_item(input logic cmd, input logic [lmfl_pkg::SYMBOL_W-1:0] sym,
                                input logic lst, input logic [lmfl_pkg::FRAME_W-1:0] frm);
        if (cmd == lmfl_pkg::CMD_PATTERN)
        begin
            if (pattern_closed)
            begin
                pattern_len    = 0;
                pattern_closed = 1'b0;
            end
            if (pattern_len < MAX_PAT)
            begin
                pattern_store[pattern_len] = sym;
                pattern_len++;
            end
            if (lst)
                pattern_closed = 1'b1;
            clear_frame_state();
        end
        else
        begin
            pattern_closed = 1'b1;
            scan_symbol(sym);
            if (lst)
                close_frame(frm);
        end
    endtask

    task automatic check_location(input logic [lmfl_pkg::OUT_DATA_W-1:0] data);
        location_t want;
        location_t got;
        got = location_t'(data[$bits(location_t)-1:0]);
        if (expected_locations.size() == 0)
        begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result transaction, data %h", $realtime, data);
            return;
        end
        want = expected_locations.pop_front();
        if (got.found !== want.found || got.start_coord !== want.start_coord ||
            got.end_coord !== want.end_coord || got.overflow !== want.overflow)
        begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $write("%0t: expected found %0d start %0d end %0d overflow %0d",
                       $realtime, want.found, want.start_coord, $signed(want.end_coord),
                       want.overflow);
                $display(", got found %0d start %0d end %0d overflow %0d",
                         got.found, got.start_coord, $signed(got.end_coord), got.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len    = 0;
            pattern_closed = 1'b1;
            clear_frame_state();
            expected_locations.delete();
            error_count    = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_location(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[lmfl_pkg::SYMBOL_W-1:0], s_axis_tlast,
                             s_axis_tdata[lmfl_pkg::SYMBOL_W +: lmfl_pkg::FRAME_W]);
        end
        failures <= error_count;
        pending  <= expected_locations.size();
    end

endmodule

// ===== tb/sv/last_match_frame_locator_test.sv =====
`timescale 1ns / 1ps

module last_match_frame_locator_test;

    typedef logic [lmfl_pkg::SYMBOL_W-1:0] symbol_t;
    typedef logic [lmfl_pkg::FRAME_W-1:0]  frame_t;

    localparam frame_t FRAME_FWD_0    = 3'd0;
    localparam frame_t FRAME_UNUSED_6 = 3'd6;
    localparam frame_t FRAME_UNUSED_7 = 3'd7;

    localparam symbol_t NT_A = "A";
    localparam symbol_t NT_C = "C";
    localparam symbol_t NT_G = "G";
    localparam symbol_t NT_T = "T";

    localparam int RANDOM_ITEMS = 1450;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lmfl_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lmfl_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int failures;
    int pending;

    symbol_t pattern_bytes[$];
    symbol_t text_bytes[$];
    int      sent_items;
    int      calm_items;

    last_match_frame_locator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    last_match_frame_locator_checker locate_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // output back-pressure
    initial
    begin
        int hold;
        int calm;
        int r;
        hold = 0;
        calm = 0;
        forever
        begin
            @(posedge clk);
            if (calm > 0)
            begin
                calm--;
                m_axis_tready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 2)
                    calm = $urandom_range(50, 300);
                else if (r < 20)
                    hold = $urandom_range(1, 3);
                else if (r < 24)
                    hold = $urandom_range(4, 12);
                else if (r < 25)
                    hold = $urandom_range(20, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_items = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic symbol_t random_symbol();
        if ($urandom_range(0, 99) >= 85)
            return symbol_t'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return NT_A;
            1: return NT_C;
            2: return NT_G;
            default: return NT_T;
        endcase
    endfunction

    task automatic send_item(input logic cmd, input symbol_t sym,
                             input logic lst, input frame_t frm);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(lmfl_pkg::IN_DATA_W - lmfl_pkg::SYMBOL_W - lmfl_pkg::FRAME_W){1'b0}},
                          frm, sym};
        s_axis_tlast  <= lst;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_pattern(input logic close);
        int i;
        for (i = 0; i < pattern_bytes.size(); i++)
            send_item(lmfl_pkg::CMD_PATTERN, pattern_bytes[i],
                      close && (i == pattern_bytes.size() - 1), frame_t'($urandom_range(0, 7)));
    endtask

    task automatic send_frame(input frame_t frm, input logic noisy);
        int i;
        int break_at;
        break_at = (noisy && $urandom_range(0, 99) < 6) ?
                   $urandom_range(0, text_bytes.size() - 1) : -1;
        for (i = 0; i < text_bytes.size(); i++)
        begin
            // stray pattern byte in the middle of a frame
            if (i == break_at)
                send_item(lmfl_pkg::CMD_PATTERN, random_symbol(), 1'($urandom_range(0, 1)), frm);
            send_item(lmfl_pkg::CMD_TEXT, text_bytes[i], i == text_bytes.size() - 1, frm);
        end
    endtask

    task automatic random_frame();
        int target;
        int r;
        int i;
        logic scramble;
        text_bytes.delete();
        target   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        scramble = $urandom_range(0, 9) == 0;
        while (text_bytes.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (scramble || pattern_bytes.size() == 0)
                text_bytes = {text_bytes, symbol_t'($urandom_range(0, 255))};
            else if (r < 25)
            begin
                for (i = 0; i < pattern_bytes.size() && i < lmfl_pkg::MAX_PAT_DEFAULT; i++)
                    text_bytes = {text_bytes, pattern_bytes[i]};
            end
            else if (r < 75)
                text_bytes = {text_bytes,
                              pattern_bytes[$urandom_range(0, pattern_bytes.size() - 1)]};
            else
                text_bytes = {text_bytes, random_symbol()};
        end
        while (text_bytes.size() > target)
            void'(text_bytes.pop_back());
        send_frame(frame_t'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic random_session();
        int r;
        int plen;
        int nframes;
        int i;
        r = $urandom_range(0, 99);
        if (r < 75)
            plen = $urandom_range(1, 4);
        else if (r < 95)
            plen = $urandom_range(5, 12);
        else
            plen = $urandom_range(13, 36);
        pattern_bytes.delete();
        for (i = 0; i < plen; i++)
            pattern_bytes = {pattern_bytes, random_symbol()};
        send_pattern($urandom_range(0, 99) >= 8);
        nframes = $urandom_range(1, 4);
        for (i = 0; i < nframes; i++)
            random_frame();
    endtask

    initial
    begin
        sent_items = 0;
        calm_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // text before any pattern
        text_bytes = '{NT_A, NT_C};
        send_frame(FRAME_FWD_0, 1'b0);

        pattern_bytes = '{NT_A};
        send_pattern(1'b1);
        text_bytes = '{NT_A};
        send_frame(lmfl_pkg::FRAME_PLUS_1, 1'b0);

        // overlapping occurrences, mirrored frame
        pattern_bytes = '{NT_A, NT_A};
        send_pattern(1'b1);
        text_bytes = '{NT_A, NT_A, NT_A};
        send_frame(lmfl_pkg::FRAME_MINUS_1, 1'b0);

        // pattern left open, closed by text
        pattern_bytes = '{8'h00, 8'hFF};
        send_pattern(1'b0);
        text_bytes = '{8'h00, 8'hFF};
        send_frame(lmfl_pkg::FRAME_MINUS_2, 1'b0);

        pattern_bytes = '{NT_C};
        send_pattern(1'b1);
        text_bytes = '{NT_C};
        send_frame(lmfl_pkg::FRAME_PLUS_2, 1'b0);
        text_bytes = '{NT_G, NT_C};
        send_frame(lmfl_pkg::FRAME_REV_0, 1'b0);
        text_bytes = '{NT_C};
        send_frame(FRAME_UNUSED_6, 1'b0);
        text_bytes = '{NT_T, NT_C};
        send_frame(FRAME_UNUSED_7, 1'b0);
        text_bytes = '{NT_G};
        send_frame(lmfl_pkg::FRAME_PLUS_1, 1'b0);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
            random_session();

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
